// File: design/sgm_pkg.sv
// shared types and constants for the sobel gradient magnitude block
// no dependencies

package sgm_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 13;
  localparam int ColW        = 13;
  localparam int RowW        = 13;
  localparam int PixW        = 8;
  localparam int GradW       = 11;
  localparam int SqW         = 21;
  localparam int SumW        = 22;
  localparam int SqrtStages  = 8;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [12:0] RowLimit    = 13'd4096;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } rgb_t;

  // one lane's view of its 3x3 window
  typedef struct packed {
    logic [PixW-1:0] p00, p01, p02;
    logic [PixW-1:0] p10, p11, p12;
    logic [PixW-1:0] p20, p21, p22;
  } win_t;

endpackage

// File: design/sgm_sqrt.sv
// pipelined floor square root, saturated at 255, one result bit per stage
// depends on sgm_pkg

module sgm_sqrt import sgm_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SumW-1:0] sum_i,
  output logic [7:0]      root_o
);

  logic [SumW-1:0] rem_q  [SqrtStages+1];
  logic [7:0]      root_q [SqrtStages+1];
  logic            sat_q  [SqrtStages+1];

  always_comb begin
    rem_q[0]  = sum_i;
    root_q[0] = '0;
    sat_q[0]  = (sum_i >= SumW'(65025));
  end

  // digit-by-digit square root by trial squares, msb of the root first
  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    localparam int B = SqrtStages - 1 - s;
    logic [7:0]      trial;
    logic [SumW-1:0] trial_sq;
    logic [SumW-1:0] rem_d;
    logic [7:0]      root_d;
    always_comb begin
      trial    = root_q[s] | 8'(1 << B);
      trial_sq = SumW'(trial) * SumW'(trial);
      rem_d    = rem_q[s];
      root_d   = (trial_sq <= rem_d) ? trial : root_q[s];
    end
    logic [SumW-1:0] rem_r;
    logic [7:0]      root_r;
    logic            sat_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        root_r <= root_d;
        sat_r  <= sat_q[s];
      end
    end
    always_comb begin
      rem_q[s+1]  = rem_r;
      root_q[s+1] = root_r;
      sat_q[s+1]  = sat_r;
    end
  end

  assign root_o = sat_q[SqrtStages] ? 8'hff : root_q[SqrtStages];

endmodule

// File: design/sgm_lane.sv
// one colour lane: sobel gradients, squares and square root
// depends on sgm_pkg, sgm_sqrt

module sgm_lane import sgm_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  win_t       win_i,
  output logic [7:0] mag_o
);

  logic signed [GradW-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [SqW-1:0]          sx_q, sy_q;
  logic [SumW-1:0]         sum_q;

  // gradients
  always_comb begin
    gx_d = GradW'(signed'({3'b0, win_i.p02}))
         + GradW'(signed'({3'b0, win_i.p12})) * GradW'(2)
         + GradW'(signed'({3'b0, win_i.p22}))
         - GradW'(signed'({3'b0, win_i.p00}))
         - GradW'(signed'({3'b0, win_i.p10})) * GradW'(2)
         - GradW'(signed'({3'b0, win_i.p20}));
    gy_d = GradW'(signed'({3'b0, win_i.p20}))
         + GradW'(signed'({3'b0, win_i.p21})) * GradW'(2)
         + GradW'(signed'({3'b0, win_i.p22}))
         - GradW'(signed'({3'b0, win_i.p00}))
         - GradW'(signed'({3'b0, win_i.p01})) * GradW'(2)
         - GradW'(signed'({3'b0, win_i.p02}));
  end

  // gradients, squares, sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      sx_q  <= SqW'(gx_q * gx_q);
      sy_q  <= SqW'(gy_q * gy_q);
      sum_q <= SumW'(sx_q) + SumW'(sy_q);
    end
  end

  sgm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .sum_i  (sum_q),
    .root_o (mag_o)
  );

endmodule

// File: design/sobel_gradient_magnitude.sv
// top level: line buffers, 3x3 window, three colour lanes and output merge
// depends on sgm_pkg, sgm_lane
//
//  channel   | valid / ready   | payload
//  ----------+-----------------+-----------------------------------------
//  pixel in  | in_valid/ready  | blue_i green_i red_i frame_start_i
//  result out| out_valid/ready | mag_blue_o mag_green_o mag_red_o frame_end_o
//  config    | cfg_we_i        | cfg_idx_i cfg_data_i
//
// a pixel is taken every cycle the pipeline can move; results pass through the
// line store read, window, gradient, square, sum and 8 root stages
// the whole pipeline advances only when the output register is free or taken
// reset clears position and valid bits and loads the configuration defaults; line stores need no clearing

module sobel_gradient_magnitude import sgm_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PixW-1:0]     blue_i,
  input  logic [PixW-1:0]     green_i,
  input  logic [PixW-1:0]     red_i,
  input  logic                frame_start_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PixW-1:0]     mag_blue_o,
  output logic [PixW-1:0]     mag_green_o,
  output logic [PixW-1:0]     mag_red_o,
  output logic                frame_end_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(MaxWidth);
  localparam int Lat   = 3 + SqrtStages;

  logic [10:0]     width_q;
  logic [12:0]     height_q;
  logic [ColW-1:0] w_eff, col_q, col_d, col_cur;
  logic [RowW-1:0] h_eff, row_q, row_d, row_cur;
  logic            adv, acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth:  width_q  <= cfg_data_i[10:0];
        RegFrameHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    w_eff = ColW'(width_q);
    if (w_eff < ColW'(3)) w_eff = ColW'(3);
    else if (w_eff > ColW'(MaxWidth)) w_eff = ColW'(MaxWidth);
    h_eff = RowW'(height_q);
    if (h_eff < RowW'(3)) h_eff = RowW'(3);
    else if (h_eff > RowW'(RowLimit)) h_eff = RowW'(RowLimit);
  end

  // pipeline moves when the output register can accept
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // raster position
  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    if (col_cur + ColW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (row_cur + RowW'(1) >= h_eff) ? '0 : row_cur + RowW'(1);
    end else begin
      col_d = col_cur + ColW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores, read registered in stage 1, written with the same address
  logic [AddrW-1:0] addr;
  rgb_t upper_mem [MaxWidth];
  rgb_t middle_mem [MaxWidth];
  rgb_t up_rd_q, mid_rd_q, cur_q;
  rgb_t cur_pix;
  logic            v1_q, emit1_q, end1_q;

  assign addr    = (col_cur < ColW'(MaxWidth)) ? col_cur[AddrW-1:0] : AddrW'(MaxWidth - 1);
  assign cur_pix = '{blue: blue_i, green: green_i, red: red_i};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_rd_q          <= upper_mem[addr];
      mid_rd_q         <= middle_mem[addr];
      upper_mem[addr]  <= middle_mem[addr];
      middle_mem[addr] <= cur_pix;
      cur_q            <= cur_pix;
      emit1_q          <= (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
      end1_q           <= (row_cur == h_eff - RowW'(1)) && (col_cur == w_eff - ColW'(1));
    end
  end

  // window shifts in stage 2 on each accepted pixel
  rgb_t win_q [3][3];
  logic v2_q, end2_q;
  logic v1_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
    end
  end

  assign v1_acc = adv && v1_q;

  always_ff @(posedge clk_i) begin
    if (v1_acc) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= cur_q;
    end
    if (adv) begin
      end2_q  <= end1_q;
    end
  end

  // per-lane windows
  win_t wb, wg, wr;
  always_comb begin
    wb = '{win_q[0][0].blue, win_q[0][1].blue, win_q[0][2].blue,
           win_q[1][0].blue, win_q[1][1].blue, win_q[1][2].blue,
           win_q[2][0].blue, win_q[2][1].blue, win_q[2][2].blue};
    wg = '{win_q[0][0].green, win_q[0][1].green, win_q[0][2].green,
           win_q[1][0].green, win_q[1][1].green, win_q[1][2].green,
           win_q[2][0].green, win_q[2][1].green, win_q[2][2].green};
    wr = '{win_q[0][0].red, win_q[0][1].red, win_q[0][2].red,
           win_q[1][0].red, win_q[1][1].red, win_q[1][2].red,
           win_q[2][0].red, win_q[2][1].red, win_q[2][2].red};
  end

  logic [7:0] mb, mg, mr;
  sgm_lane u_lane_b (.clk_i(clk_i), .en_i(adv), .win_i(wb), .mag_o(mb));
  sgm_lane u_lane_g (.clk_i(clk_i), .en_i(adv), .win_i(wg), .mag_o(mg));
  sgm_lane u_lane_r (.clk_i(clk_i), .en_i(adv), .win_i(wr), .mag_o(mr));

  // control tracks the lane pipeline
  logic [Lat-1:0] vld_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      vld_q <= '0;
    end else if (adv) begin
      v2_q  <= v1_q && emit1_q;
      vld_q <= {vld_q[Lat-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      end_q <= {end_q[Lat-2:0], end2_q};
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_blue_o  <= mb;
      mag_green_o <= mg;
      mag_red_o   <= mr;
      frame_end_o <= end_q[Lat-1];
    end
  end

  // a stalled output holds its request
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(mag_red_o))
    else $error("output request dropped during stall");

  // no new pixel while output is blocked
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // position stays in range
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> col_q <= ColW'(MaxWidth))
    else $error("column position out of range");

endmodule
